// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRSEW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRSEW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrsew_pkg.sv =====
package rrsew_pkg;

    // Block dimensions.
    localparam int CHANNELS  = 4;
    localparam int WINDOW    = 100;

    // Derived widths.
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam int ADDR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Output field widths.
    localparam int CHAN_OUT_W = 2;
    localparam int COUNT_W    = 7;
    localparam int COUNT_MAX  = 127;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NORESP   = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_OTHER    = 2'd3
    } status_t;

    // One measurement request.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] temp_high;
        logic [7:0] temp_low;
        logic [7:0] hum_high;
        logic [7:0] hum_low;
        logic       sensor_kind;
    } meas_t;

    // One result.
    typedef struct packed {
        logic [CHAN_OUT_W-1:0] channel;
        logic                  event_res;
        logic                  kind_changed;
        logic [COUNT_W-1:0]    noresp_count;
        logic [COUNT_W-1:0]    checksum_count;
        logic [7:0]            out_temp_high;
        logic [7:0]            out_temp_low;
        logic [7:0]            out_hum_high;
        logic [7:0]            out_hum_low;
        logic                  out_kind;
    } res_t;

    // Status ring read and write ports.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ring_rd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        data;
    } ring_wr_t;

endpackage

// ===== rtl/core/rrsew_status_ring.sv =====
module rrsew_status_ring
    import rrsew_pkg::*;
(
    input  logic       clk,
    input  ring_rd_t   rd,
    input  ring_wr_t   wr,
    output logic [1:0] rd_data
);

    logic [1:0] mem [RING_DEPTH];
    logic [1:0] rd_data_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/round_robin_sensor_error_window_unit.sv =====
// Channel  Direction  Handshake               Payload
// meas     in         meas_valid/meas_ready   meas  (rrsew_pkg::meas_t)
// res      out        res_valid/res_ready     res   (rrsew_pkg::res_t)
//
// One request is accepted per cycle unless res stalls; it moves via the input stage into the result register.
// The rate is set by the single status ring port pair: one read at acceptance and
// one write when the request moves into the result register.
// Reset clears all channel state at once; ring entries not yet written in a channel's
// first pass read as ok through a per-channel filled flag, so no clearing pass is run.
// A stalled result holds the pipeline; meas_ready drops only while res is stalled.
module round_robin_sensor_error_window_unit
    import rrsew_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  meas_valid,
    output logic  meas_ready,
    input  meas_t meas,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

`include "assert_macros.svh"

    // Channel pointer and per-channel state.
    logic [CH_W-1:0]  chan_reg;
    logic [POS_W-1:0] write_pos_reg [CHANNELS];
    logic             filled_reg    [CHANNELS];
    logic [CNT_W-1:0] noresp_reg    [CHANNELS];
    logic [CNT_W-1:0] checksum_reg  [CHANNELS];
    logic [31:0]      reading_reg   [CHANNELS];
    logic             kind_reg      [CHANNELS];

    // Input stage.
    logic              s1_valid_reg;
    meas_t             s1_item_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_old_valid_reg;

    // Result register.
    logic res_valid_reg;
    res_t res_reg;

    logic              accept;
    logic              advance;
    logic [POS_W-1:0]  cur_pos;
    logic [ADDR_W-1:0] cur_addr;
    ring_rd_t          ring_rd;
    ring_wr_t          ring_wr;
    logic [1:0]        ring_rd_data;

    logic [1:0]       old_status;
    logic             is_ok;
    logic [CNT_W-1:0] nr_cur;
    logic [CNT_W-1:0] cs_cur;
    logic [CNT_W-1:0] nr_dec;
    logic [CNT_W-1:0] cs_dec;
    logic [CNT_W-1:0] nr_next;
    logic [CNT_W-1:0] cs_next;
    logic [31:0]      reading_next;
    logic             kind_next;
    logic             changed;
    res_t             res_next;
    logic [CNT_W:0]   cnt_sum;

    // Handshake: the input stage drains whenever the result register is free.
    assign advance    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign meas_ready = !s1_valid_reg || advance;
    assign accept     = meas_valid && meas_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Ring address of the oldest entry of the current channel.
    assign cur_pos  = write_pos_reg[chan_reg];
    assign cur_addr = ADDR_W'(chan_reg) * ADDR_W'(WINDOW) + ADDR_W'(cur_pos);

    assign ring_rd.en   = accept;
    assign ring_rd.addr = cur_addr;
    assign ring_wr.en   = advance;
    assign ring_wr.addr = s1_addr_reg;
    assign ring_wr.data = s1_item_reg.status;

    rrsew_status_ring u_ring (
        .clk     (clk),
        .rd      (ring_rd),
        .wr      (ring_wr),
        .rd_data (ring_rd_data)
    );

    // Window update: retire the oldest status, then admit the new one.
    always_comb
    begin
        old_status = s1_old_valid_reg ? ring_rd_data : ST_OK;
        is_ok      = (s1_item_reg.status == ST_OK);
        nr_cur     = noresp_reg[s1_ch_reg];
        cs_cur     = checksum_reg[s1_ch_reg];

        nr_dec = ((old_status == ST_NORESP) && (nr_cur != '0)) ? nr_cur - 1'b1 : nr_cur;
        cs_dec = ((old_status == ST_CHECKSUM) && (cs_cur != '0)) ? cs_cur - 1'b1 : cs_cur;
        nr_next = (s1_item_reg.status == ST_NORESP) ? nr_dec + 1'b1 : nr_dec;
        cs_next = (s1_item_reg.status == ST_CHECKSUM) ? cs_dec + 1'b1 : cs_dec;

        changed      = is_ok && (kind_reg[s1_ch_reg] != s1_item_reg.sensor_kind);
        reading_next = is_ok ? {s1_item_reg.temp_high, s1_item_reg.temp_low,
                                s1_item_reg.hum_high, s1_item_reg.hum_low}
                             : reading_reg[s1_ch_reg];
        kind_next    = is_ok ? s1_item_reg.sensor_kind : kind_reg[s1_ch_reg];

        res_next.channel        = CHAN_OUT_W'(s1_ch_reg);
        res_next.event_res      = !is_ok;
        res_next.kind_changed   = changed;
        res_next.noresp_count   = (int'(nr_next) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                              : COUNT_W'(nr_next);
        res_next.checksum_count = (int'(cs_next) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                              : COUNT_W'(cs_next);
        res_next.out_temp_high  = reading_next[31:24];
        res_next.out_temp_low   = reading_next[23:16];
        res_next.out_hum_high   = reading_next[15:8];
        res_next.out_hum_low    = reading_next[7:0];
        res_next.out_kind       = kind_next;
    end

    // Channel pointer, write positions and filled flags advance at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                write_pos_reg[i] <= '0;
                filled_reg[i]    <= 1'b0;
            end
        end
        else if (accept)
        begin
            chan_reg <= (int'(chan_reg) == CHANNELS - 1) ? '0 : chan_reg + 1'b1;
            if (int'(cur_pos) == WINDOW - 1)
            begin
                write_pos_reg[chan_reg] <= '0;
                filled_reg[chan_reg]    <= 1'b1;
            end
            else
            begin
                write_pos_reg[chan_reg] <= cur_pos + 1'b1;
            end
        end
    end

    // Input stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (meas_ready)
        begin
            s1_valid_reg <= meas_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg      <= meas;
            s1_ch_reg        <= chan_reg;
            s1_addr_reg      <= cur_addr;
            s1_old_valid_reg <= filled_reg[chan_reg];
        end
    end

    // Per-channel counts and stored data update as the request leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                noresp_reg[i]   <= '0;
                checksum_reg[i] <= '0;
                reading_reg[i]  <= '0;
                kind_reg[i]     <= 1'b0;
            end
        end
        else if (advance)
        begin
            noresp_reg[s1_ch_reg]   <= nr_next;
            checksum_reg[s1_ch_reg] <= cs_next;
            reading_reg[s1_ch_reg]  <= reading_next;
            kind_reg[s1_ch_reg]     <= kind_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // The two counts of a channel together never exceed the window.
    assign cnt_sum = {1'b0, nr_cur} + {1'b0, cs_cur};

    `RRSEW_ASSERT_NOW(a_window_bound, s1_valid_reg, int'(cnt_sum) <= WINDOW, "window counts exceed window")
    `RRSEW_ASSERT_NOW(a_ring_no_collision, ring_rd.en && ring_wr.en, ring_rd.addr != ring_wr.addr, "ring read and write collide")
    `RRSEW_ASSERT_NOW(a_ready_only_on_stall, !meas_ready, res_valid && !res_ready, "input stalled without output stall")
    `RRSEW_ASSERT_NEXT(a_advance_fills_result, advance, res_valid, "advanced request lost")

endmodule
